[hw/rtl/scp_pkg.sv]
// Shared types and constants of the sine/cosine pipeline.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package scp_pkg;

    typedef struct packed {
        logic signed [31:0] angle;
        logic               last_in;
    } scp_in_t;

    typedef struct packed {
        logic signed [31:0] sin_value;
        logic signed [31:0] cos_value;
        logic               last_out;
    } scp_out_t;

    // Quadrant codes taken from the top two phase bits.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [1:0] quad;
        logic       last;
    } scp_side_t;

    // round(2^32 / (2*pi)) and round(pi/2 * 2^30).
    localparam logic [29:0] INV_TWO_PI_K = 30'd683565276;
    localparam logic [30:0] PI_HALF_Q30  = 31'd1686629713;
    localparam logic [30:0] ONE_Q30_U    = 31'h4000_0000;

    localparam int ACC_W    = 48;
    localparam int HI_W     = ACC_W - 32;
    localparam int NUM_COEF = 8;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Even polynomial coefficients in Q40, lowest order first.
    localparam acc_t POLY_Q40 [NUM_COEF] = '{
        48'sd1099511627776,
        -48'sd549755813888,
        48'sd45812984490,
        -48'sd1527099480,
        48'sd27269629,
        -48'sd302992,
        48'sd2293,
        -48'sd12
    };

    // Argument and square stages, then two stages per Horner step.
    localparam int POLY_LAT = 2 + 2 * (NUM_COEF - 1);

endpackage

`default_nettype wire

[hw/rtl/sine_cosine_polynomial.sv]
// Sine and cosine of a Q8.24 angle as Q2.30. A result beat comes out with
// done after the start beat is taken, having passed angle reduction, the
// polynomial lanes (argument, square, then the Horner steps) and a last
// register of rounding and quadrant signs. A new angle is taken
// every cycle; busy stays low and the receiver cannot stall. Reset clears only
// the valid bits, so no result comes out until an angle is started after reset.
`default_nettype none

module sine_cosine_polynomial
    import scp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire scp_in_t arg,
    output logic         done,
    output scp_out_t     result
);

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    logic        ph_valid;
    logic [31:0] phase;
    logic        ph_last;
    logic [30:0] r_a;
    logic [30:0] r_b;

    logic        valid_a;
    logic        valid_b;
    acc_t        acc_a;
    acc_t        acc_b;

    scp_side_t   side_reg [POLY_LAT];
    scp_side_t   side_out;

    logic signed [31:0] pa;
    logic signed [31:0] pb;
    scp_out_t    result_next;
    scp_out_t    result_reg;
    logic        done_reg;

    // Rounds Q40 to Q30 (half up) and clamps to plus or minus one.
    function automatic logic signed [31:0] round_clamp(input acc_t a);
        acc_t                    biased;
        logic signed [ACC_W-11:0] v;
        begin
            biased = a + acc_t'(512);
            v      = biased[ACC_W-1:10];
            if (v > (ACC_W-10)'(ONE_Q30))
            begin
                round_clamp = ONE_Q30;
            end
            else if (v < -(ACC_W-10)'(ONE_Q30))
            begin
                round_clamp = -ONE_Q30;
            end
            else
            begin
                round_clamp = v[31:0];
            end
        end
    endfunction

    assign busy = 1'b0;

    scp_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .arg       (arg),
        .out_valid (ph_valid),
        .phase     (phase),
        .last      (ph_last)
    );

    // Lane A evaluates the offset, lane B its complement to a quarter turn.
    assign r_a = {1'b0, phase[29:0]};
    assign r_b = ONE_Q30_U - r_a;

    scp_poly u_lane_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .r         (r_a),
        .out_valid (valid_a),
        .acc       (acc_a)
    );

    scp_poly u_lane_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .r         (r_b),
        .out_valid (valid_b),
        .acc       (acc_b)
    );

    // Quadrant and last flag ride alongside the lanes.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{quad: phase[31:30], last: ph_last};
        for (int i = 1; i < POLY_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_out = side_reg[POLY_LAT-1];
    assign pa       = round_clamp(acc_a);
    assign pb       = round_clamp(acc_b);

    always_comb
    begin
        result_next.last_out = side_out.last;
        unique case (side_out.quad)
            QUAD_1:
            begin
                result_next.sin_value = pa;
                result_next.cos_value = -pb;
            end
            QUAD_2:
            begin
                result_next.sin_value = -pb;
                result_next.cos_value = -pa;
            end
            QUAD_3:
            begin
                result_next.sin_value = -pa;
                result_next.cos_value = pb;
            end
            QUAD_0:
            begin
                result_next.sin_value = pb;
                result_next.cos_value = pa;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_a & valid_b;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[hw/rtl/scp_phase.sv]
// Angle reduction: multiplies by 1/(2*pi) and keeps the fraction of a turn.
// Depends on scp_pkg.
`default_nettype none

module scp_phase
    import scp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire scp_in_t     arg,
    output logic             out_valid,
    output logic [31:0]      phase,
    output logic             last
);

    logic signed [62:0] prod;
    logic               valid_reg;
    logic [31:0]        phase_reg;
    logic [31:0]        phase_next;
    logic               last_reg;

    // Signed product; the low 32 bits of the integer part wrap, which
    // handles negative angles as well.
    assign prod       = arg.angle * $signed({1'b0, INV_TWO_PI_K});
    assign phase_next = prod[55:24];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        last_reg  <= arg.last_in;
    end

    assign out_valid = valid_reg;
    assign phase     = phase_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[hw/rtl/scp_horner.sv]
// One Horner step acc*y2 + coef, rounded to Q40, in two register stages.
// Depends on scp_pkg.
`default_nettype none

module scp_horner
    import scp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire acc_t        acc_in,
    input  wire logic [31:0] y2_in,
    input  wire acc_t        coef,
    output logic             out_valid,
    output acc_t             acc_out,
    output logic [31:0]      y2_out
);

    logic [ACC_W-1:0] mag;
    logic [HI_W+31:0] hi_prod_next;
    logic [63:0]      lo_prod_next;

    logic             valid_a_reg;
    logic             neg_a_reg;
    logic [HI_W+31:0] hi_prod_reg;
    logic [63:0]      lo_prod_reg;
    logic [31:0]      y2_a_reg;

    logic [63:0]      lo_rnd;
    logic [HI_W+34:0] res;
    acc_t             res_mag;
    acc_t             acc_next;

    logic             valid_b_reg;
    acc_t             acc_reg;
    logic [31:0]      y2_b_reg;

    // Magnitude split into a high part and a 32-bit low part, each
    // multiplied on its own.
    assign mag          = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);
    assign hi_prod_next = (HI_W+32)'(mag[ACC_W-1:32]) * (HI_W+32)'(y2_in);
    assign lo_prod_next = 64'(mag[31:0]) * 64'(y2_in);

    // Shifting the high product left by two is exact, so only the low
    // product needs the rounding bias.
    assign lo_rnd   = lo_prod_reg + 64'h2000_0000;
    assign res      = {1'b0, hi_prod_reg, 2'b00} + (HI_W+35)'(lo_rnd[63:30]);
    assign res_mag  = acc_t'(res[ACC_W-1:0]);
    assign acc_next = (neg_a_reg ? -res_mag : res_mag) + coef;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_a_reg   <= acc_in[ACC_W-1];
        hi_prod_reg <= hi_prod_next;
        lo_prod_reg <= lo_prod_next;
        y2_a_reg    <= y2_in;
        acc_reg     <= acc_next;
        y2_b_reg    <= y2_a_reg;
    end

    assign out_valid = valid_b_reg;
    assign acc_out   = acc_reg;
    assign y2_out    = y2_b_reg;

endmodule

`default_nettype wire

[hw/rtl/scp_poly.sv]
// One polynomial lane: argument scaling, squaring and the Horner chain.
// Depends on scp_pkg and scp_horner.
`default_nettype none

module scp_poly
    import scp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [30:0] r,
    output logic             out_valid,
    output acc_t             acc
);

    logic [61:0] y_prod;
    logic [61:0] y_rnd;
    logic [61:0] sq_rnd;
    logic        valid_y_reg;
    logic [30:0] y_reg;
    logic        valid_sq_reg;
    logic [31:0] y2_reg;

    logic        valid_chain [NUM_COEF];
    acc_t        acc_chain   [NUM_COEF];
    logic [31:0] y2_chain    [NUM_COEF];

    assign y_prod = 62'(r) * 62'(PI_HALF_Q30);
    assign y_rnd  = y_prod + 62'h2000_0000;
    assign sq_rnd = 62'(y_reg) * 62'(y_reg) + 62'h2000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_y_reg  <= 1'b0;
            valid_sq_reg <= 1'b0;
        end
        else
        begin
            valid_y_reg  <= in_valid;
            valid_sq_reg <= valid_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg  <= y_rnd[60:30];
        y2_reg <= sq_rnd[61:30];
    end

    // The chain starts from the highest coefficient.
    assign valid_chain[0] = valid_sq_reg;
    assign acc_chain[0]   = POLY_Q40[NUM_COEF-1];
    assign y2_chain[0]    = y2_reg;

    for (genvar i = 0; i < NUM_COEF - 1; i++)
    begin : g_step
        scp_horner u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[i]),
            .acc_in    (acc_chain[i]),
            .y2_in     (y2_chain[i]),
            .coef      (POLY_Q40[NUM_COEF-2-i]),
            .out_valid (valid_chain[i+1]),
            .acc_out   (acc_chain[i+1]),
            .y2_out    (y2_chain[i+1])
        );
    end

    assign out_valid = valid_chain[NUM_COEF-1];
    assign acc       = acc_chain[NUM_COEF-1];

endmodule

`default_nettype wire

[hw/rtl/scp_checker.sv]
// Port-level checks of the sine/cosine pipeline, bound to its top level.
// Depends on scp_pkg and sine_cosine_polynomial.
`default_nettype none

module scp_checker
    import scp_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire scp_in_t  arg,
    input wire logic     done,
    input wire scp_out_t result
);

    localparam int LAT = POLY_LAT + 2;

    // Every accepted beat produces exactly one result a fixed time later.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat produced no result");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted beat");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.last_out == $past(arg.last_in, LAT)))
        else $error("last flag out of order");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.sin_value <= 32'sh4000_0000)
               && (result.sin_value >= -32'sh4000_0000)
               && (result.cos_value <= 32'sh4000_0000)
               && (result.cos_value >= -32'sh4000_0000)))
        else $error("result outside plus or minus one");

endmodule

bind sine_cosine_polynomial scp_checker u_checker (.*);

`default_nettype wire
